FILE: design/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared constants, codes and types of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  // Field widths of the transactions
  localparam int unsigned ActW  = 3;
  localparam int unsigned PosW  = 7;
  localparam int unsigned DataW = 32;
  localparam int unsigned StatW = 3;

  // List geometry
  localparam int unsigned Depth     = 64;
  localparam int unsigned CntW      = $clog2(Depth + 1);
  localparam int unsigned IdxW      = $clog2(Depth);
  localparam int unsigned CmpW      = ((CntW > PosW) ? CntW : PosW) + 1;

  // Result scan: cells are examined one group per cycle
  localparam int unsigned GroupSize = 8;
  localparam int unsigned SubW      = $clog2(GroupSize);
  localparam int unsigned NumGroups = (Depth + GroupSize - 1) / GroupSize;
  localparam int unsigned GrpW      = (NumGroups > 1) ? $clog2(NumGroups) : 1;
  localparam int unsigned PadDepth  = NumGroups * GroupSize;
  localparam int unsigned PadIdxW   = $clog2(PadDepth);

  typedef enum logic [ActW-1:0] {
    ACT_APPEND = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_SEARCH = 3'd3,
    ACT_UPDATE = 3'd4,
    ACT_CLEAR  = 3'd5
  } action_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // Per-cycle command broadcast to every cell
  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_WRITE  = 3'd1,
    CELL_INSERT = 3'd2,
    CELL_REMOVE = 3'd3,
    CELL_PROBE  = 3'd4,
    CELL_UPDATE = 3'd5
  } cell_op_e;

  typedef struct packed {
    cell_op_e             op;
    logic [IdxW-1:0]      sel;
    logic [CntW-1:0]      count;
    logic [DataW-1:0]     value;
  } cell_ctl_t;

  typedef struct packed {
    status_e              status;
    logic [PosW-1:0]      found_position;
    logic [DataW-1:0]     data_out;
    logic [PosW-1:0]      entry_count;
  } rsp_t;

endpackage

FILE: design/ple_in_if.sv
// ----------------------------------------------------------------------------
// ple_in_if
// Request channel: one list action per transaction.
// ----------------------------------------------------------------------------
interface ple_in_if import ple_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ActW-1:0]         action;
  logic [PosW-1:0]         position;
  logic signed [DataW-1:0] new_value;

  modport source (output valid, action, position, new_value, input ready);
  modport sink   (input valid, action, position, new_value, output ready);
endinterface

FILE: design/ple_out_if.sv
// ----------------------------------------------------------------------------
// ple_out_if
// Response channel: one result per request.
// ----------------------------------------------------------------------------
interface ple_out_if import ple_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [StatW-1:0]        status;
  logic [PosW-1:0]         found_position;
  logic signed [DataW-1:0] data_out;
  logic [PosW-1:0]         entry_count;

  modport source (output valid, status, found_position, data_out, entry_count,
                  input ready);
  modport sink   (input valid, status, found_position, data_out, entry_count,
                  output ready);
endinterface

FILE: design/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an entry, shifts with its neighbors, compares on probe.
// ----------------------------------------------------------------------------
module ple_cell import ple_pkg::*; (
  input  logic             clk_i,
  input  cell_ctl_t        ctl_i,
  input  logic [IdxW-1:0]  idx_i,
  input  logic [DataW-1:0] left_i,
  input  logic [DataW-1:0] right_i,
  output logic [DataW-1:0] entry_o,
  output logic             match_o,
  output logic [DataW-1:0] tap_o
);

  logic [DataW-1:0] entry_q;
  logic             match_q;
  logic [DataW-1:0] tap_q;
  logic             at_sel;
  logic             past_sel;
  logic             in_list;

  assign at_sel   = (idx_i == ctl_i.sel);
  assign past_sel = (idx_i > ctl_i.sel);
  assign in_list  = (CntW'(idx_i) < ctl_i.count);

  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      CELL_WRITE: begin
        if (at_sel) entry_q <= ctl_i.value;
      end
      CELL_INSERT: begin
        if (past_sel) entry_q <= left_i;
        else if (at_sel) entry_q <= ctl_i.value;
      end
      CELL_REMOVE: begin
        if (past_sel || at_sel) entry_q <= right_i;
      end
      CELL_PROBE: begin
        match_q <= in_list && (entry_q == ctl_i.value);
      end
      CELL_UPDATE: begin
        // old value goes to the tap, zero elsewhere so taps can be OR-ed
        tap_q <= at_sel ? entry_q : '0;
        if (at_sel) entry_q <= ctl_i.value;
      end
      default: begin
      end
    endcase
  end

  assign entry_o = entry_q;
  assign match_o = match_q;
  assign tap_o   = tap_q;

endmodule

FILE: design/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one action per transaction (append, insert, remove, search,
//   update, clear) with a one-based position and a value. rsp_o returns one
//   result per request: status, found position, data word and the entry
//   count after the action.
//   All cells act in the cycle a request is accepted: insert and remove shift
//   every later entry by one place in that single edge.
//   Append, insert, remove, clear and every rejected action: the result is
//   registered at the accepting edge; a new request can be taken every
//   cycle while the receiver keeps up.
//   Update: cells capture the old value at accept, the owning group of eight
//   taps is OR-ed in the next cycle; no new request is taken meanwhile.
//   Search: cells compare at accept, then the match flags are scanned one
//   group of eight per cycle, stopping at the first hit or after the last
//   group; no new request is taken until the scan ends.
//   Reset clears the entry count, the scan state and the output valid; entry
//   contents are left as they are and are never read before being written.
//   A stalled receiver holds the result in the output register; a new
//   request is taken only once that register is free or being emptied.
// ----------------------------------------------------------------------------
module positional_list_engine import ple_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ple_in_if.sink    req_i,
  ple_out_if.source rsp_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  // control state
  logic            state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;
  logic [GrpW-1:0] grp_q, grp_d;

  // payload
  rsp_t             out_q, out_d;
  logic             out_load;
  logic             find_q;
  logic [DataW-1:0] value_q;

  logic fire;

  // --- request decode against the current count ---
  logic [CmpW-1:0] pos_x, cnt_x;
  logic            pos_zero, list_full, list_empty, past_len, past_tail;
  logic [IdxW-1:0] sel_pos;
  cell_op_e        dec_op;
  logic [IdxW-1:0] dec_sel;
  status_e         dec_status;
  logic [CntW-1:0] dec_count;
  logic            dec_scan;

  assign pos_x      = CmpW'(req_i.position);
  assign cnt_x      = CmpW'(count_q);
  assign pos_zero   = (req_i.position == '0);
  assign list_full  = (count_q == CntW'(Depth));
  assign list_empty = (count_q == '0);
  assign past_len   = (pos_x > cnt_x);
  assign past_tail  = (pos_x > (cnt_x + CmpW'(1)));
  assign sel_pos    = IdxW'(pos_x - CmpW'(1));

  always_comb begin
    dec_op     = CELL_HOLD;
    dec_sel    = sel_pos;
    dec_status = ST_OK;
    dec_count  = count_q;
    dec_scan   = 1'b0;
    case (req_i.action)
      ACT_APPEND: begin
        if (list_full) begin
          dec_status = ST_FULL;
        end else begin
          dec_op    = CELL_WRITE;
          dec_sel   = IdxW'(count_q);
          dec_count = count_q + CntW'(1);
        end
      end
      ACT_INSERT: begin
        if (pos_zero || past_tail) begin
          dec_status = ST_RANGE;
        end else if (list_full) begin
          dec_status = ST_FULL;
        end else begin
          dec_op    = CELL_INSERT;
          dec_count = count_q + CntW'(1);
        end
      end
      ACT_REMOVE: begin
        if (list_empty) begin
          dec_status = ST_EMPTY;
        end else if (pos_zero || past_len) begin
          dec_status = ST_RANGE;
        end else begin
          dec_op    = CELL_REMOVE;
          dec_count = count_q - CntW'(1);
        end
      end
      ACT_SEARCH: begin
        if (list_empty) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_op   = CELL_PROBE;
          dec_scan = 1'b1;
        end
      end
      ACT_UPDATE: begin
        if (list_empty) begin
          dec_status = ST_EMPTY;
        end else if (pos_zero || past_len) begin
          dec_status = ST_RANGE;
        end else begin
          dec_op   = CELL_UPDATE;
          dec_scan = 1'b1;
        end
      end
      ACT_CLEAR: begin
        dec_count = '0;
      end
      default: begin
        dec_status = ST_RANGE;
      end
    endcase
  end

  // --- cell row ---
  cell_ctl_t        ctl;
  logic [DataW-1:0] entry [Depth];
  logic [DataW-1:0] tap   [Depth];
  logic [Depth-1:0] match;

  assign ctl.op    = fire ? dec_op : CELL_HOLD;
  assign ctl.sel   = dec_sel;
  assign ctl.count = count_q;
  assign ctl.value = req_i.new_value;

  for (genvar k = 0; k < Depth; k++) begin : g_cell
    logic [DataW-1:0] left_w, right_w;
    if (k == 0) begin : g_head
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = entry[k-1];
    end
    if (k == Depth - 1) begin : g_tail
      assign right_w = entry[k];
    end else begin : g_body
      assign right_w = entry[k+1];
    end
    ple_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .idx_i   (IdxW'(k)),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry[k]),
      .match_o (match[k]),
      .tap_o   (tap[k])
    );
  end

  // --- group scan over match flags and taps ---
  logic [PadDepth-1:0] match_pad;
  logic [DataW-1:0]    tap_pad [PadDepth];
  logic [GroupSize-1:0] grp_bits;
  logic [DataW-1:0]    tap_or;
  logic [SubW-1:0]     hit_sub;
  logic                grp_hit;
  logic [PadIdxW:0]    hit_pos;

  always_comb begin
    match_pad = '0;
    match_pad[Depth-1:0] = match;
    for (int i = 0; i < PadDepth; i++) begin
      tap_pad[i] = (i < Depth) ? tap[i] : '0;
    end
  end

  always_comb begin
    tap_or  = '0;
    hit_sub = '0;
    for (int i = 0; i < GroupSize; i++) begin
      grp_bits[i] = match_pad[PadIdxW'({grp_q, SubW'(i)})];
      tap_or      = tap_or | tap_pad[PadIdxW'({grp_q, SubW'(i)})];
    end
    for (int i = GroupSize - 1; i >= 0; i--) begin
      if (grp_bits[i]) hit_sub = SubW'(i);
    end
    grp_hit = |grp_bits;
    hit_pos = {1'b0, PadIdxW'({grp_q, hit_sub})} + (PadIdxW + 1)'(1);
  end

  assign fire = req_i.valid && req_i.ready;

  // --- sequencing ---
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    grp_d    = grp_q;
    out_load = 1'b0;
    out_d    = out_q;
    case (state_q)
      S_IDLE: begin
        if (fire) begin
          count_d = dec_count;
          if (dec_scan) begin
            state_d = S_SCAN;
            grp_d   = (req_i.action == ACT_SEARCH) ? '0 : GrpW'(dec_sel / GroupSize);
          end else begin
            out_load             = 1'b1;
            out_d.status         = dec_status;
            out_d.found_position = '0;
            out_d.data_out       = '0;
            out_d.entry_count    = PosW'(dec_count);
          end
        end
      end
      S_SCAN: begin
        out_d.entry_count    = PosW'(count_q);
        out_d.found_position = '0;
        out_d.data_out       = '0;
        if (!find_q) begin
          // update: target group was selected at accept
          out_load       = 1'b1;
          out_d.status   = ST_OK;
          out_d.data_out = tap_or;
          state_d        = S_IDLE;
        end else if (grp_hit) begin
          out_load             = 1'b1;
          out_d.status         = ST_OK;
          out_d.found_position = PosW'(hit_pos);
          out_d.data_out       = value_q;
          state_d              = S_IDLE;
        end else if (grp_q == GrpW'(NumGroups - 1)) begin
          out_load     = 1'b1;
          out_d.status = ST_NOTFOUND;
          state_d      = S_IDLE;
        end else begin
          grp_d = grp_q + GrpW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      grp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      grp_q       <= grp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= out_d;
    if (fire) begin
      find_q  <= (req_i.action == ACT_SEARCH);
      value_q <= req_i.new_value;
    end
  end

  // --- ports ---
  assign req_i.ready          = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_q.status;
  assign rsp_o.found_position = out_q.found_position;
  assign rsp_o.data_out       = out_q.data_out;
  assign rsp_o.entry_count    = out_q.entry_count;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("entry count above list depth");

  a_search_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && req_i.action == ACT_SEARCH && count_q != '0) |=> state_q == S_SCAN)
    else $error("accepted search did not enter the scan");

  a_scan_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> !out_valid_q)
    else $error("output register busy during scan");

  a_found_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.found_position != '0) |->
      (rsp_o.found_position <= rsp_o.entry_count && rsp_o.status == ST_OK))
    else $error("found position outside the list");
`endif

endmodule

FILE: bench/ple_result_checker.sv
// ----------------------------------------------------------------------------
// ple_result_checker
// Watches the request and response channels of the positional list engine.
// Keeps a shadow copy of the list, works out the result of each accepted
// request and compares every response field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module ple_result_checker import ple_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ple_in_if           req_mon,
  ple_out_if          rsp_mon,
  output int unsigned fail_count_o,
  output int unsigned awaited_o,
  output int unsigned list_len_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DataW-1:0] shadow_cells [Depth];
  int unsigned      shadow_len = 0;
  rsp_t             awaited_rsp [$];
  rsp_t             head_rsp;
  int unsigned      mismatches = 0;

  // Apply one list action to the shadow copy and return its response.
  function automatic rsp_t apply_action(input logic [ActW-1:0]  act,
                                        input logic [PosW-1:0]  pos,
                                        input logic [DataW-1:0] val);
    rsp_t        r;
    int unsigned p;
    int unsigned k;
    r.status         = ST_OK;
    r.found_position = '0;
    r.data_out       = '0;
    p = pos;
    case (act)
      ACT_APPEND: begin
        if (shadow_len >= Depth) begin
          r.status = ST_FULL;
        end else begin
          shadow_cells[shadow_len] = val;
          shadow_len++;
        end
      end
      ACT_INSERT: begin
        // range is checked ahead of fullness
        if (p == 0 || p > shadow_len + 1) begin
          r.status = ST_RANGE;
        end else if (shadow_len >= Depth) begin
          r.status = ST_FULL;
        end else begin
          for (k = shadow_len; k > p - 1; k--) shadow_cells[k] = shadow_cells[k-1];
          shadow_cells[p-1] = val;
          shadow_len++;
        end
      end
      ACT_REMOVE: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else if (p == 0 || p > shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          for (k = p - 1; k + 1 < shadow_len; k++) shadow_cells[k] = shadow_cells[k+1];
          shadow_len--;
        end
      end
      ACT_SEARCH: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_NOTFOUND;
          for (k = 0; k < shadow_len; k++) begin
            if (r.status == ST_NOTFOUND && shadow_cells[k] == val) begin
              r.status         = ST_OK;
              r.found_position = PosW'(k + 1);
              r.data_out       = shadow_cells[k];
            end
          end
        end
      end
      ACT_UPDATE: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else if (p == 0 || p > shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          r.data_out        = shadow_cells[p-1];
          shadow_cells[p-1] = val;
        end
      end
      ACT_CLEAR: shadow_len = 0;
      default:   r.status = ST_RANGE;
    endcase
    r.entry_count = PosW'(shadow_len);
    return r;
  endfunction

  task automatic note_diff(input string field, input logic [DataW-1:0] want,
                           input logic [DataW-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // Response first: a response never belongs to a request accepted at the
  // same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_len = 0;
      awaited_rsp.delete();
    end else begin
      if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
        if (awaited_rsp.size() == 0) begin
          mismatches++;
          $display("%0t: response with no request outstanding, expected none, actual %0h",
                   $time, rsp_mon.status);
        end else begin
          head_rsp = awaited_rsp.pop_front();
          note_diff("status", DataW'(head_rsp.status), DataW'(rsp_mon.status));
          note_diff("found_position", DataW'(head_rsp.found_position),
                    DataW'(rsp_mon.found_position));
          note_diff("data_out", head_rsp.data_out, rsp_mon.data_out);
          note_diff("entry_count", DataW'(head_rsp.entry_count),
                    DataW'(rsp_mon.entry_count));
        end
      end
      if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
        awaited_rsp.push_back(apply_action(req_mon.action, req_mon.position,
                                           req_mon.new_value));
      end
    end
    fail_count_o = mismatches;
    awaited_o    = awaited_rsp.size();
    list_len_o   = shadow_len;
  end

endmodule

FILE: bench/positional_list_engine_tb.sv
// ----------------------------------------------------------------------------
// positional_list_engine_tb
// Drives list actions into the positional list engine and gives the verdict.
// A short directed pass walks the empty, range and duplicate cases; random
// episodes then fill, drain and churn the list with random handshake gaps.
// ----------------------------------------------------------------------------
module positional_list_engine_tb import ple_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ItemTarget   = 1400;
  localparam int unsigned CalmTail     = 200;     // last items run with no idling
  localparam int unsigned SettleCycles = 16;      // longer than the slowest search
  localparam int unsigned CycleLimit   = 400000;

  // action codes the block does not define; both must be rejected
  localparam logic [ActW-1:0] ActUnusedLo = 3'd6;
  localparam logic [ActW-1:0] ActUnusedHi = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  int unsigned sent        = 0;
  int unsigned idle_pct    = 0;   // odds of a gap before each request
  int unsigned stall_pct   = 0;   // odds of a receiver stall each cycle
  int unsigned fail_count;
  int unsigned awaited;
  int unsigned list_len;
  int unsigned cycle_count = 0;

  ple_in_if  req_ch ();
  ple_out_if rsp_ch ();

  positional_list_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  ple_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_ch),
    .rsp_mon      (rsp_ch),
    .fail_count_o (fail_count),
    .awaited_o    (awaited),
    .list_len_o   (list_len)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // single reset at the start, released on a falling edge
  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: ready drops in random bursts at the current odds.
  initial begin
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        rsp_ch.ready = 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk_i);
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  // Values lean on a small pool so searches hit and duplicates show up;
  // the rest are extremes or fully random words.
  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return DataW'($urandom_range(0, 7));
      5: begin
        case ($urandom_range(0, 2))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Position in 1..hi most of the time, otherwise zero or past the end.
  function automatic logic [PosW-1:0] fit_pos(input int unsigned hi);
    if (hi == 0 || $urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 2))
        0:       return '0;
        1:       return PosW'(hi + 1);
        default: return PosW'($urandom_range(hi + 1, 127));
      endcase
    end
    return PosW'($urandom_range(1, hi));
  endfunction

  // Ends on a falling edge where the next request may be presented.
  // A random gap may lower valid first.
  task automatic await_slot();
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 13) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
  endtask

  // Present one request and hold it until the transaction completes.
  task automatic push_item(input logic [ActW-1:0] act, input logic [PosW-1:0] pos,
                           input logic [DataW-1:0] val);
    req_ch.valid     = 1'b1;
    req_ch.action    = act;
    req_ch.position  = pos;
    req_ch.new_value = val;
    sent++;
    @(posedge clk_i);
    while (req_ch.ready !== 1'b1) @(posedge clk_i);
  endtask

  task automatic issue(input logic [ActW-1:0] act, input logic [PosW-1:0] pos,
                       input logic [DataW-1:0] val);
    await_slot();
    push_item(act, pos, val);
  endtask

  initial begin
    int unsigned burst;
    req_ch.valid     = 1'b0;
    req_ch.action    = '0;
    req_ch.position  = '0;
    req_ch.new_value = '0;
    @(posedge rst_ni);

    // ---- directed: empty list, range edges, duplicates, unused codes ----
    issue(ACT_SEARCH, 7'd1,   32'd0);          // empty
    issue(ACT_REMOVE, 7'd1,   32'd0);          // empty
    issue(ACT_UPDATE, 7'd1,   32'd0);          // empty
    issue(ACT_INSERT, 7'd0,   32'd1);          // position zero
    issue(ACT_INSERT, 7'd2,   32'd1);          // past count+1 on empty list
    issue(ACT_INSERT, 7'd1,   32'h7FFF_FFFF);  // insert into empty list
    issue(ACT_APPEND, 7'd127, 32'h8000_0000);
    issue(ACT_APPEND, 7'd0,   32'hFFFF_FFFF);
    issue(ACT_INSERT, 7'd127, 32'd5);          // far past the end
    issue(ACT_INSERT, 7'd4,   32'd0);          // at count+1, i.e. the tail
    issue(ACT_SEARCH, 7'd0,   32'h8000_0000);
    issue(ACT_SEARCH, 7'd0,   32'd12345);      // no match
    issue(ACT_UPDATE, 7'd0,   32'd9);
    issue(ACT_UPDATE, 7'd5,   32'd9);          // one past count
    issue(ACT_UPDATE, 7'd4,   32'h5555_5555);
    issue(ACT_UPDATE, 7'd1,   32'hAAAA_AAAA);
    issue(ACT_REMOVE, 7'd0,   32'd0);
    issue(ACT_REMOVE, 7'd5,   32'd0);
    issue(ACT_REMOVE, 7'd1,   32'd0);          // head
    issue(ActUnusedLo, 7'd1,  32'd0);
    issue(ActUnusedHi, 7'd127, 32'hFFFF_FFFF);
    issue(ACT_REMOVE, 7'd3,   32'd0);          // tail
    issue(ACT_INSERT, 7'd1,   32'hFFFF_FFFF);  // duplicate ahead of the old one
    issue(ACT_SEARCH, 7'd0,   32'hFFFF_FFFF);  // must report the first copy
    issue(ACT_CLEAR,  7'd0,   32'd0);
    issue(ACT_SEARCH, 7'd0,   32'd0);          // empty again after clear

    // ---- random episodes ----
    while (sent < ItemTarget) begin
      if (sent + CalmTail > ItemTarget) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 4))
          0:       begin idle_pct = 0;  stall_pct = 0;  end
          1:       begin idle_pct = 8;  stall_pct = 8;  end
          2:       begin idle_pct = 30; stall_pct = 5;  end
          3:       begin idle_pct = 5;  stall_pct = 30; end
          default: begin idle_pct = 20; stall_pct = 20; end
        endcase
      end

      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // churn: every action but clear, positions mostly in range
          burst = $urandom_range(20, 40);
          repeat (burst) begin
            await_slot();
            case ($urandom_range(0, 9))
              0, 1: push_item(ACT_APPEND, PosW'($urandom_range(0, 127)), pick_value());
              2, 3: push_item(ACT_INSERT, fit_pos(list_len + 1), pick_value());
              4, 5: push_item(ACT_REMOVE, fit_pos(list_len), pick_value());
              6, 7: push_item(ACT_SEARCH, PosW'($urandom_range(0, 127)), pick_value());
              default: push_item(ACT_UPDATE, fit_pos(list_len), pick_value());
            endcase
          end
        end
        4, 5: begin
          // fill to the brim, then knock on the full list
          forever begin
            await_slot();
            if (list_len >= Depth) begin
              req_ch.valid = 1'b0;
              break;
            end
            if ($urandom_range(0, 5) == 0) begin
              push_item(ACT_APPEND, PosW'($urandom_range(0, 127)), pick_value());
            end else begin
              push_item(ACT_INSERT, PosW'($urandom_range(1, list_len + 1)), pick_value());
            end
          end
          repeat ($urandom_range(1, 3)) begin
            await_slot();
            case ($urandom_range(0, 2))
              0:       push_item(ACT_APPEND, '0, pick_value());
              1:       push_item(ACT_INSERT, PosW'(Depth + 1), pick_value());
              default: push_item(ACT_INSERT, fit_pos(Depth + 1), pick_value());
            endcase
          end
        end
        6, 7: begin
          // drain to empty with searches and updates mixed in
          forever begin
            await_slot();
            if (list_len == 0) begin
              req_ch.valid = 1'b0;
              break;
            end
            case ($urandom_range(0, 7))
              0:       push_item(ACT_SEARCH, '0, pick_value());
              1:       push_item(ACT_UPDATE, fit_pos(list_len), pick_value());
              default: push_item(ACT_REMOVE, PosW'($urandom_range(1, list_len)),
                                 pick_value());
            endcase
          end
          repeat ($urandom_range(1, 3)) begin
            await_slot();
            case ($urandom_range(0, 2))
              0:       push_item(ACT_REMOVE, fit_pos(1), pick_value());
              1:       push_item(ACT_SEARCH, '0, pick_value());
              default: push_item(ACT_UPDATE, fit_pos(1), pick_value());
            endcase
          end
        end
        8: begin
          await_slot();
          push_item(ACT_CLEAR, PosW'($urandom_range(0, 127)), $urandom());
        end
        default: begin
          // raw noise over every code and position
          burst = $urandom_range(5, 15);
          repeat (burst) begin
            await_slot();
            push_item(ActW'($urandom_range(0, 7)), PosW'($urandom_range(0, 127)), $urandom());
          end
        end
      endcase
    end

    @(negedge clk_i);
    req_ch.valid = 1'b0;

    // drain outstanding responses, then let any late extra one show up
    while (awaited != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);

    if (fail_count == 0 && awaited == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
design/ple_pkg.sv
design/ple_in_if.sv
design/ple_out_if.sv
design/ple_cell.sv
design/positional_list_engine.sv
bench/ple_result_checker.sv
bench/positional_list_engine_tb.sv
